>>> hdl/sslc_pkg.sv
// ----------------------------------------------------------------------------
// sslc_pkg
// Shared constants, register codes and tables for the sphere slice vertex
// generator.
// ----------------------------------------------------------------------------
package sslc_pkg;

	localparam int SSLC_MAX_STACKS      = 256;
	localparam int SSLC_MAX_SECTORS     = 256;
	localparam int SSLC_TRIG_ITERATIONS = 16;

	// quotient bits of the angle dividers
	localparam int SSLC_QW = 17;

	localparam logic signed [32:0] SSLC_CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [32:0] SSLC_ONE_Q30     = 33'sd1073741824;

	localparam logic [15:0]        SSLC_RADIUS_RST   = 16'd256;
	localparam logic [8:0]         SSLC_STACKS_RST   = 9'd16;
	localparam logic [8:0]         SSLC_SECTORS_RST  = 9'd32;
	localparam logic signed [15:0] SSLC_START_RST    = 16'sd16384;
	localparam logic signed [15:0] SSLC_END_RST      = -16'sd16384;

	typedef enum logic [2:0] {
		REG_RADIUS       = 3'd0,
		REG_ORIGIN_X     = 3'd1,
		REG_ORIGIN_Y     = 3'd2,
		REG_ORIGIN_Z     = 3'd3,
		REG_STACK_COUNT  = 3'd4,
		REG_SECTOR_COUNT = 3'd5,
		REG_START_ANGLE  = 3'd6,
		REG_END_ANGLE    = 3'd7
	} cfg_reg_t;

	// cordic step angles, 2^32 per turn
	function automatic logic signed [31:0] sslc_atan(input int k);
		logic signed [31:0] a;
		unique case (k)
			0:       a = 32'sd536870912;
			1:       a = 32'sd316933406;
			2:       a = 32'sd167458907;
			3:       a = 32'sd85004756;
			4:       a = 32'sd42667331;
			5:       a = 32'sd21354465;
			6:       a = 32'sd10679838;
			7:       a = 32'sd5340245;
			8:       a = 32'sd2670163;
			9:       a = 32'sd1335087;
			10:      a = 32'sd667544;
			11:      a = 32'sd333772;
			12:      a = 32'sd166886;
			13:      a = 32'sd83443;
			14:      a = 32'sd41722;
			15:      a = 32'sd20861;
			16:      a = 32'sd10430;
			17:      a = 32'sd5215;
			18:      a = 32'sd2608;
			19:      a = 32'sd1304;
			20:      a = 32'sd652;
			21:      a = 32'sd326;
			22:      a = 32'sd163;
			23:      a = 32'sd81;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

endpackage

>>> hdl/sslc_delay.sv
// ----------------------------------------------------------------------------
// sslc_delay
// Enabled shift line that keeps side data and valid bits aligned with a
// pipelined unit.
// ----------------------------------------------------------------------------
module sslc_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [0:DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) tap_q[k] <= '0;
		end else if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) tap_q[k] <= tap_q[k-1];
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

>>> hdl/sslc_div.sv
// ----------------------------------------------------------------------------
// sslc_div
// Pipelined restoring divider, one quotient bit per stage, msb first.
// The dividend must be below divisor * 2^QW.
// ----------------------------------------------------------------------------
module sslc_div #(
	parameter int NW = 9,
	parameter int QW = 17
) (
	input  logic               clk,
	input  logic               en,
	input  logic [NW+QW-1:0]   dividend,
	input  logic [NW-1:0]      divisor,
	output logic [QW-1:0]      quotient
);

	localparam int DW = NW + QW;

	logic [DW-1:0] rem_q [0:QW-1];
	logic [NW-1:0] dv_q  [0:QW-1];
	logic [QW-1:0] qt_q  [0:QW];

	assign rem_q[0] = dividend;
	assign dv_q[0]  = divisor;
	assign qt_q[0]  = '0;

	for (genvar t = 0; t < QW; t++) begin : g_stage
		localparam int K = QW - 1 - t;
		logic [DW-1:0] sh;
		logic          ge;
		logic [QW-1:0] qn;

		always_comb begin
			sh = DW'(dv_q[t]) << K;
			ge = rem_q[t] >= sh;
			qn = qt_q[t] | (QW'(ge) << K);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qt_q[t+1] <= qn;
			end
		end

		if (t < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[t+1] <= ge ? rem_q[t] - sh : rem_q[t];
					dv_q[t+1]  <= dv_q[t];
				end
			end
		end
	end

	assign quotient = qt_q[QW];

endmodule

>>> hdl/sslc_cordic.sv
// ----------------------------------------------------------------------------
// sslc_cordic
// Pipelined cordic rotation giving cos and sin in Q30 of a 16-bit angle,
// one rotation per stage, then clamp and quadrant mapping.
// ----------------------------------------------------------------------------
module sslc_cordic import sslc_pkg::*; #(
	parameter int ITER = SSLC_TRIG_ITERATIONS
) (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        angle,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o
);

	logic signed [32:0] x_q [0:ITER];
	logic signed [32:0] y_q [0:ITER];
	logic signed [31:0] z_q [0:ITER-1];
	logic [1:0]         qd_q [0:ITER];

	assign x_q[0]  = SSLC_CORDIC_GAIN;
	assign y_q[0]  = '0;
	assign z_q[0]  = {2'b00, angle[13:0], 16'h0000};
	assign qd_q[0] = angle[15:14];

	for (genvar k = 0; k < ITER; k++) begin : g_rot
		logic signed [32:0] dx, dy;

		always_comb begin
			dx = y_q[k] >>> k;
			dy = x_q[k] >>> k;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[k][31]) begin
					x_q[k+1] <= x_q[k] - dx;
					y_q[k+1] <= y_q[k] + dy;
				end else begin
					x_q[k+1] <= x_q[k] + dx;
					y_q[k+1] <= y_q[k] - dy;
				end
				qd_q[k+1] <= qd_q[k];
			end
		end

		if (k < ITER - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					z_q[k+1] <= z_q[k][31] ? z_q[k] + sslc_atan(k) : z_q[k] - sslc_atan(k);
				end
			end
		end
	end

	logic signed [31:0] xc, yc;

	always_comb begin
		if (x_q[ITER] > SSLC_ONE_Q30)       xc = 32'(SSLC_ONE_Q30);
		else if (x_q[ITER] < -SSLC_ONE_Q30) xc = 32'(-SSLC_ONE_Q30);
		else                                xc = 32'(x_q[ITER]);
		if (y_q[ITER] > SSLC_ONE_Q30)       yc = 32'(SSLC_ONE_Q30);
		else if (y_q[ITER] < -SSLC_ONE_Q30) yc = 32'(-SSLC_ONE_Q30);
		else                                yc = 32'(y_q[ITER]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (qd_q[ITER])
				2'd0: begin cos_o <= xc;  sin_o <= yc;  end
				2'd1: begin cos_o <= -yc; sin_o <= xc;  end
				2'd2: begin cos_o <= -xc; sin_o <= -yc; end
				default: begin cos_o <= yc; sin_o <= -xc; end
			endcase
		end
	end

endmodule

>>> hdl/sphere_slice_vertex_generator.sv
// ----------------------------------------------------------------------------
// sphere_slice_vertex_generator
// Position and unit normal of one grid point of a uv sphere slice.
// ----------------------------------------------------------------------------
// One grid point enters per clock unless the pipeline is stalled; it stalls
// as a whole while the output register holds an untaken result. Between
// input and output lie the two 17-stage angle dividers and the two cordic
// pipelines that run side by side. Configuration must be written with the
// pipeline empty.
module sphere_slice_vertex_generator import sslc_pkg::*; #(
	parameter int MAX_STACKS      = SSLC_MAX_STACKS,
	parameter int MAX_SECTORS     = SSLC_MAX_SECTORS,
	parameter int TRIG_ITERATIONS = SSLC_TRIG_ITERATIONS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // stack_index[8:0], sector_index[17:9]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
	output logic [0:0]   m_tuser,   // saturated
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int NSTW = $clog2(MAX_STACKS + 1);
	localparam int NSEW = $clog2(MAX_SECTORS + 1);
	localparam int QW   = SSLC_QW;

	// configuration registers
	logic [15:0]        radius_q;
	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [8:0]         stack_count_q, sector_count_q;
	logic signed [15:0] start_q, end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= SSLC_RADIUS_RST;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			origin_z_q     <= '0;
			stack_count_q  <= SSLC_STACKS_RST;
			sector_count_q <= SSLC_SECTORS_RST;
			start_q        <= SSLC_START_RST;
			end_q          <= SSLC_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS:       radius_q       <= cfg_data[15:0];
				REG_ORIGIN_X:     origin_x_q     <= cfg_data;
				REG_ORIGIN_Y:     origin_y_q     <= cfg_data;
				REG_ORIGIN_Z:     origin_z_q     <= cfg_data;
				REG_STACK_COUNT:  stack_count_q  <= cfg_data[8:0];
				REG_SECTOR_COUNT: sector_count_q <= cfg_data[8:0];
				REG_START_ANGLE:  start_q        <= cfg_data[15:0];
				REG_END_ANGLE:    end_q          <= cfg_data[15:0];
			endcase
		end
	end

	logic en;
	logic v_s7;

	assign en       = !v_s7 || m_tready;
	assign s_tready = en;

	// stage 1: clamp counts and indexes, stack interpolation product
	logic               trim_top, trim_bot;
	logic signed [16:0] st_c, en_c;
	logic signed [17:0] diff_c;
	logic [NSTW-1:0]    nst_c, i_c;
	logic [NSEW-1:0]    nse_c, j_c;
	logic signed [NSTW+18:0] num_c;

	always_comb begin
		trim_top = start_q < 16'sd16384;
		trim_bot = end_q > -16'sd16384;
		st_c     = trim_top ? 17'(start_q) : 17'sd16384;
		en_c     = trim_bot ? 17'(end_q) : -17'sd16384;
		diff_c   = 18'(st_c) - 18'(en_c);

		if (stack_count_q == '0)                    nst_c = NSTW'(1);
		else if (int'(stack_count_q) > MAX_STACKS)  nst_c = NSTW'(MAX_STACKS);
		else                                        nst_c = NSTW'(stack_count_q);
		if (sector_count_q == '0)                   nse_c = NSEW'(1);
		else if (int'(sector_count_q) > MAX_SECTORS) nse_c = NSEW'(MAX_SECTORS);
		else                                        nse_c = NSEW'(sector_count_q);

		i_c = (int'(s_tdata[8:0]) > int'(nst_c)) ? nst_c : NSTW'(s_tdata[8:0]);
		j_c = (int'(s_tdata[17:9]) > int'(nse_c)) ? nse_c : NSEW'(s_tdata[17:9]);

		num_c = $signed({1'b0, i_c}) * diff_c;
	end

	logic                    v_s1, top_s1, bot_s1;
	logic signed [NSTW+18:0] num_s1;
	logic [NSTW-1:0]         nst_s1;
	logic [NSEW-1:0]         nse_s1, j_s1;
	logic [15:0]             st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1   <= s_tvalid;
			num_s1 <= num_c;
			nst_s1 <= nst_c;
			nse_s1 <= nse_c;
			j_s1   <= j_c;
			st_s1  <= st_c[15:0];
			top_s1 <= trim_top && (i_c == '0);
			bot_s1 <= !(trim_top && (i_c == '0)) && trim_bot && (i_c == nst_c);
		end
	end

	// stage 2: divider operands with round-to-nearest offsets
	logic                 neg_c;
	logic [NSTW+18:0]     mag_c;

	always_comb begin
		neg_c = num_s1[NSTW+18];
		mag_c = neg_c ? 19'(0) - num_s1 : num_s1;
	end

	logic                 v_s2;
	logic [NSTW+QW-1:0]   dvd_st_s2;
	logic [NSEW+QW-1:0]   dvd_th_s2;
	logic [NSTW-1:0]      nst_s2;
	logic [NSEW-1:0]      nse_s2;
	logic [18:0]          side_s2;  // neg, start angle, top cap, bottom cap

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2      <= v_s1;
			dvd_st_s2 <= (NSTW+QW)'(mag_c) + (NSTW+QW)'(nst_s1 >> 1);
			dvd_th_s2 <= ((NSEW+QW)'(j_s1) << 16) + (NSEW+QW)'(nse_s1 >> 1);
			nst_s2    <= nst_s1;
			nse_s2    <= nse_s1;
			side_s2   <= {neg_c, st_s1, top_s1, bot_s1};
		end
	end

	logic [QW-1:0] q_st, q_th;
	logic [19:0]   side_d;

	sslc_div #(.NW(NSTW), .QW(QW)) u_div_stack (
		.clk(clk), .en(en), .dividend(dvd_st_s2), .divisor(nst_s2), .quotient(q_st)
	);

	sslc_div #(.NW(NSEW), .QW(QW)) u_div_sector (
		.clk(clk), .en(en), .dividend(dvd_th_s2), .divisor(nse_s2), .quotient(q_th)
	);

	sslc_delay #(.WIDTH(20), .DEPTH(QW)) u_div_side (
		.clk(clk), .arst_n(arst_n), .en(en), .din({v_s2, side_s2}), .dout(side_d)
	);

	// stage 3: angles, modulo one turn
	logic        v_s3, top_s3, bot_s3;
	logic [15:0] phi_s3, theta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3     <= side_d[19];
			phi_s3   <= side_d[18] ? side_d[17:2] + q_st[15:0] : side_d[17:2] - q_st[15:0];
			theta_s3 <= q_th[15:0];
			top_s3   <= side_d[1];
			bot_s3   <= side_d[0];
		end
	end

	logic signed [31:0] cp, sp, ct, stt;
	logic [2:0]         cap_d;

	sslc_cordic #(.ITER(TRIG_ITERATIONS)) u_trig_stack (
		.clk(clk), .en(en), .angle(phi_s3), .cos_o(cp), .sin_o(sp)
	);

	sslc_cordic #(.ITER(TRIG_ITERATIONS)) u_trig_sector (
		.clk(clk), .en(en), .angle(theta_s3), .cos_o(ct), .sin_o(stt)
	);

	sslc_delay #(.WIDTH(3), .DEPTH(TRIG_ITERATIONS + 1)) u_trig_side (
		.clk(clk), .arst_n(arst_n), .en(en), .din({v_s3, top_s3, bot_s3}), .dout(cap_d)
	);

	// stage 4: radius products and trig products
	logic signed [16:0] ny_r;
	always_comb ny_r = 17'((33'(sp) + 33'sd32768) >>> 16);

	logic               v_s4, top_s4, bot_s4;
	logic signed [48:0] ry_p_s4, ring_p_s4;
	logic signed [63:0] nx_p_s4, nz_p_s4;
	logic signed [31:0] ct_s4, stt_s4;
	logic signed [15:0] ny_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4      <= cap_d[2];
			top_s4    <= cap_d[1];
			bot_s4    <= cap_d[0];
			ry_p_s4   <= $signed({1'b0, radius_q}) * sp;
			ring_p_s4 <= $signed({1'b0, radius_q}) * cp;
			nx_p_s4   <= cp * stt;
			nz_p_s4   <= cp * ct;
			ct_s4     <= ct;
			stt_s4    <= stt;
			if (ny_r > 17'sd16384)       ny_s4 <= 16'sd16384;
			else if (ny_r < -17'sd16384) ny_s4 <= -16'sd16384;
			else                         ny_s4 <= 16'(ny_r);
		end
	end

	// stage 5: round ring radius, y offset and normals
	logic signed [17:0] nx_r, nz_r;
	always_comb begin
		nx_r = 18'((nx_p_s4 + 64'sd35184372088832) >>> 46);
		nz_r = 18'((nz_p_s4 + 64'sd35184372088832) >>> 46);
	end

	logic               v_s5, top_s5, bot_s5;
	logic signed [26:0] ring_s5, ry_s5;
	logic signed [31:0] ct_s5, stt_s5;
	logic signed [15:0] nx_s5, ny_s5, nz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5    <= v_s4;
			top_s5  <= top_s4;
			bot_s5  <= bot_s4;
			ring_s5 <= 27'((50'(ring_p_s4) + 50'sd2097152) >>> 22);
			ry_s5   <= 27'((50'(ry_p_s4) + 50'sd2097152) >>> 22);
			ct_s5   <= ct_s4;
			stt_s5  <= stt_s4;
			ny_s5   <= ny_s4;
			if (nx_r > 18'sd16384)       nx_s5 <= 16'sd16384;
			else if (nx_r < -18'sd16384) nx_s5 <= -16'sd16384;
			else                         nx_s5 <= 16'(nx_r);
			if (nz_r > 18'sd16384)       nz_s5 <= 16'sd16384;
			else if (nz_r < -18'sd16384) nz_s5 <= -16'sd16384;
			else                         nz_s5 <= 16'(nz_r);
		end
	end

	// stage 6: ring times sector direction
	logic               v_s6, top_s6, bot_s6;
	logic signed [58:0] rx_p_s6, rz_p_s6;
	logic signed [26:0] ry_s6;
	logic signed [15:0] nx_s6, ny_s6, nz_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6    <= v_s5;
			top_s6  <= top_s5;
			bot_s6  <= bot_s5;
			rx_p_s6 <= ring_s5 * stt_s5;
			rz_p_s6 <= ring_s5 * ct_s5;
			ry_s6   <= ry_s5;
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			nz_s6   <= nz_s5;
		end
	end

	// stage 7: cap rows, origin offset with saturation
	logic               cap;
	logic signed [31:0] rx, rz;
	logic signed [33:0] sx, sy, sz;
	logic signed [31:0] px, py, pz;
	logic signed [15:0] nx, ny, nz;
	logic               sat;

	always_comb begin
		cap = top_s6 || bot_s6;
		rx  = cap ? 32'sd0 : 32'((rx_p_s6 + 59'sd536870912) >>> 30);
		rz  = cap ? 32'sd0 : 32'((rz_p_s6 + 59'sd536870912) >>> 30);
		nx  = cap ? 16'sd0 : nx_s6;
		nz  = cap ? 16'sd0 : nz_s6;
		if (top_s6)      ny = ny_s6[15] ? -ny_s6 : ny_s6;
		else if (bot_s6) ny = ny_s6[15] ? ny_s6 : -ny_s6;
		else             ny = ny_s6;

		sx = 34'(origin_x_q) + 34'(rx);
		sy = 34'(origin_y_q) + 34'(ry_s6);
		sz = 34'(origin_z_q) + 34'(rz);
		sat = 1'b0;
		if (sx > 34'sd2147483647)       begin px = 32'h7fffffff; sat = 1'b1; end
		else if (sx < -34'sd2147483648) begin px = 32'h80000000; sat = 1'b1; end
		else                            px = 32'(sx);
		if (sy > 34'sd2147483647)       begin py = 32'h7fffffff; sat = 1'b1; end
		else if (sy < -34'sd2147483648) begin py = 32'h80000000; sat = 1'b1; end
		else                            py = 32'(sy);
		if (sz > 34'sd2147483647)       begin pz = 32'h7fffffff; sat = 1'b1; end
		else if (sz < -34'sd2147483648) begin pz = 32'h80000000; sat = 1'b1; end
		else                            pz = 32'(sz);
	end

	logic [144:0] out_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7   <= v_s6;
			out_s7 <= {sat, nz, ny, nx, pz, py, px};
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = {8'h00, out_s7[143:0]};
	assign m_tuser  = out_s7[144];

`ifndef SYNTHESIS
	// top cap row: normal on the axis pointing north
	a_top_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s6 && top_s6) |=>
		(m_tdata[111:96] == 16'h0000 && m_tdata[143:128] == 16'h0000 && !m_tdata[127]))
		else $error("top cap normal wrong");

	// bottom cap row: normal on the axis pointing south
	a_bot_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s6 && bot_s6) |=>
		(m_tdata[111:96] == 16'h0000 && m_tdata[143:128] == 16'h0000 &&
		 (m_tdata[127] || m_tdata[127:112] == 16'h0000)))
		else $error("bottom cap normal wrong");

	// a flagged transfer carries a clamped component
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
		(m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
		 m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
		 m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000))
		else $error("saturated flag without clamp");

	// an empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
`endif

endmodule
